// ===== rtl/core/c39_pkg.sv =====
// ----------------------------------------------------------------------------
// c39_pkg
// Shared types, constants and the bar pattern table for the Code 39 bar
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package c39_pkg;

   // element counts of one symbol
   localparam int unsigned PATTERN_WIDTH  = 9;
   localparam int unsigned BARS_PER_CHAR  = 5;
   localparam int unsigned BAR_IDX_WIDTH  = 3;
   localparam int unsigned OFFSET_WIDTH   = 3;
   localparam int unsigned CHAR_WIDTH     = 8;

   // default depth of the queue between front and back (power of two, >= 2)
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // index of the final bar of a symbol
   localparam logic [BAR_IDX_WIDTH-1:0] LAST_BAR_IDX = BAR_IDX_WIDTH'(BARS_PER_CHAR - 1);

   typedef logic [PATTERN_WIDTH-1:0] pattern_type;
   typedef logic [CHAR_WIDTH-1:0]    char_type;
   typedef logic [OFFSET_WIDTH-1:0]  offset_type;
   typedef logic [BAR_IDX_WIDTH-1:0] bar_idx_type;

   // one classified character waiting for the bar sequencer
   typedef struct packed {
      pattern_type pattern;
      logic        start_new;
      logic        show_label;
      char_type    label_char;
   } entry_type;

   // upper-case fold for a..z
   function automatic char_type to_upper(input char_type code);
      char_type folded;
      folded = code;
      if (code >= 8'h61 && code <= 8'h7a) begin
         folded = code - 8'h20;
      end
      return folded;
   endfunction

   // wide/narrow pattern, first element in bit 8, zero when no symbol exists
   function automatic pattern_type lookup_pattern(input char_type code);
      pattern_type pat;
      case (code)
         8'h20:   pat = 9'o304;
         8'h24:   pat = 9'o250;
         8'h25:   pat = 9'o052;
         8'h2a:   pat = 9'o224;
         8'h2b:   pat = 9'o212;
         8'h2d:   pat = 9'o205;
         8'h2e:   pat = 9'o604;
         8'h2f:   pat = 9'o242;
         8'h30:   pat = 9'o064;
         8'h31:   pat = 9'o441;
         8'h32:   pat = 9'o141;
         8'h33:   pat = 9'o540;
         8'h34:   pat = 9'o061;
         8'h35:   pat = 9'o460;
         8'h36:   pat = 9'o160;
         8'h37:   pat = 9'o045;
         8'h38:   pat = 9'o444;
         8'h39:   pat = 9'o144;
         8'h41:   pat = 9'o411;
         8'h42:   pat = 9'o111;
         8'h43:   pat = 9'o510;
         8'h44:   pat = 9'o031;
         8'h45:   pat = 9'o430;
         8'h46:   pat = 9'o130;
         8'h47:   pat = 9'o015;
         8'h48:   pat = 9'o414;
         8'h49:   pat = 9'o114;
         8'h4a:   pat = 9'o034;
         8'h4b:   pat = 9'o403;
         8'h4c:   pat = 9'o103;
         8'h4d:   pat = 9'o502;
         8'h4e:   pat = 9'o023;
         8'h4f:   pat = 9'o422;
         8'h50:   pat = 9'o122;
         8'h51:   pat = 9'o007;
         8'h52:   pat = 9'o406;
         8'h53:   pat = 9'o106;
         8'h54:   pat = 9'o026;
         8'h55:   pat = 9'o601;
         8'h56:   pat = 9'o301;
         8'h57:   pat = 9'o700;
         8'h58:   pat = 9'o221;
         8'h59:   pat = 9'o620;
         8'h5a:   pat = 9'o320;
         default: pat = '0;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/c39_front.sv =====
// ----------------------------------------------------------------------------
// c39_front
// Accepts characters, folds case, looks up the bar pattern and drops
// characters without a symbol. A start_new on a dropped character is held
// and handed to the next symbol that is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module c39_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire c39_pkg::char_type     req_char_code,
   input  wire logic                  req_show_label,
   input  wire logic                  req_start_new,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output c39_pkg::entry_type         push_entry
);

   c39_pkg::char_type    upper_char;
   c39_pkg::pattern_type pattern;
   logic                 has_symbol;
   logic                 accept;
   logic                 clear_held_ff;
   logic                 clear_held_in;

   // classify the incoming character
   always_comb begin
      upper_char = c39_pkg::to_upper(req_char_code);
      pattern    = c39_pkg::lookup_pattern(upper_char);
      has_symbol = (pattern != '0);
   end

   // the front never stalls except on a full queue
   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && has_symbol;

   always_comb begin
      push_entry.pattern    = pattern;
      push_entry.start_new  = req_start_new || clear_held_ff;
      push_entry.show_label = req_show_label;
      push_entry.label_char = upper_char;
   end

   // pending clear from a dropped beat
   always_comb begin
      clear_held_in = clear_held_ff;
      if (accept) begin
         if (has_symbol) begin
            clear_held_in = 1'b0;
         end else if (req_start_new) begin
            clear_held_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_held_ff <= 1'b0;
      end else begin
         clear_held_ff <= clear_held_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/c39_queue.sv =====
// ----------------------------------------------------------------------------
// c39_queue
// Small register queue of classified characters between the front and the
// bar sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module c39_queue #(
   parameter int unsigned Depth = c39_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire c39_pkg::entry_type    push_entry,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output c39_pkg::entry_type         pop_entry
);

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   c39_pkg::entry_type    store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/c39_back.sv =====
// ----------------------------------------------------------------------------
// c39_back
// Bar sequencer: walks the five bars of the head queue entry into the output
// register, one bar per cycle unless rsp_ready stalls it, and keeps the
// running offset carried between characters.
// ----------------------------------------------------------------------------
`default_nettype none

module c39_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire c39_pkg::entry_type    pop_entry,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output c39_pkg::offset_type        rsp_bar_offset,
   output logic                       rsp_wide_bar,
   output logic                       rsp_label_valid,
   output c39_pkg::char_type          rsp_label_char,
   output logic                       rsp_last_bar
);

   c39_pkg::bar_idx_type bar_idx_ff;
   c39_pkg::bar_idx_type bar_idx_in;
   c39_pkg::offset_type  pending_ff;
   c39_pkg::offset_type  pending_in;
   logic                 prev_wide_ff;
   logic                 prev_wide_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   c39_pkg::offset_type  offset_ff;
   logic                 wide_ff;
   logic                 label_valid_ff;
   c39_pkg::char_type    label_char_ff;
   logic                 last_ff;

   logic                 advance;
   logic                 is_first;
   logic                 is_last;
   logic                 bar_wide;
   logic                 space_wide;
   c39_pkg::offset_type  base;
   c39_pkg::offset_type  bar_offset;

   // a bar moves when the output register is free or being drained
   assign advance   = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign is_first  = (bar_idx_ff == '0);
   assign is_last   = (bar_idx_ff == c39_pkg::LAST_BAR_IDX);
   assign pop_ready = advance && is_last;

   // pick this bar and the space before it
   always_comb begin
      case (bar_idx_ff)
         3'd0:    begin bar_wide = pop_entry.pattern[8]; space_wide = 1'b0;                 end
         3'd1:    begin bar_wide = pop_entry.pattern[6]; space_wide = pop_entry.pattern[7]; end
         3'd2:    begin bar_wide = pop_entry.pattern[4]; space_wide = pop_entry.pattern[5]; end
         3'd3:    begin bar_wide = pop_entry.pattern[2]; space_wide = pop_entry.pattern[3]; end
         3'd4:    begin bar_wide = pop_entry.pattern[0]; space_wide = pop_entry.pattern[1]; end
         default: begin bar_wide = 1'b0;                 space_wide = 1'b0;                 end
      endcase
   end

   // distance from the previous bar
   always_comb begin
      if (is_first) begin
         base = pop_entry.start_new ? '0 : pending_ff;
      end else begin
         base = (prev_wide_ff ? 3'd2 : 3'd1) + (space_wide ? 3'd3 : 3'd1);
      end
      bar_offset = base + {2'b00, bar_wide};
   end

   // sequencer state
   always_comb begin
      bar_idx_in   = bar_idx_ff;
      prev_wide_in = prev_wide_ff;
      pending_in   = pending_ff;
      if (advance) begin
         prev_wide_in = bar_wide;
         if (is_last) begin
            bar_idx_in = '0;
            // trailing run after the last bar plus the intercharacter gap
            pending_in = bar_wide ? 3'd3 : 3'd2;
         end else begin
            bar_idx_in = bar_idx_ff + 1'b1;
         end
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_idx_ff   <= '0;
         prev_wide_ff <= 1'b0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bar_idx_ff   <= bar_idx_in;
         prev_wide_ff <= prev_wide_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (advance) begin
         offset_ff      <= bar_offset;
         wide_ff        <= bar_wide;
         label_valid_ff <= is_first && pop_entry.show_label;
         label_char_ff  <= (is_first && pop_entry.show_label) ? pop_entry.label_char : '0;
         last_ff        <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bar_offset  = offset_ff;
   assign rsp_wide_bar    = wide_ff;
   assign rsp_label_valid = label_valid_ff;
   assign rsp_label_char  = label_char_ff;
   assign rsp_last_bar    = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/code39_bar_encoder_unit.sv =====
// Path: a character's bars pass through the entry queue, then the output register, to rsp_.
// Throughput: one bar per cycle from the bar sequencer into the output register unless
//   rsp_ready stalls it; characters without a symbol produce no bars.
// Reset (synchronous): clears carried offset, queue and output valid.
// ----------------------------------------------------------------------------
// code39_bar_encoder_unit
// Code 39 bar encoder: front classifier, entry queue and bar sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module code39_bar_encoder_unit #(
   parameter int unsigned QueueDepth = c39_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire c39_pkg::char_type     req_char_code,
   input  wire logic                  req_show_label,
   input  wire logic                  req_start_new,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output c39_pkg::offset_type        rsp_bar_offset,
   output logic                       rsp_wide_bar,
   output logic                       rsp_label_valid,
   output c39_pkg::char_type          rsp_label_char,
   output logic                       rsp_last_bar
);

   logic               push_valid;
   logic               push_ready;
   c39_pkg::entry_type push_entry;
   logic               pop_valid;
   logic               pop_ready;
   c39_pkg::entry_type pop_entry;

   // classify characters
   c39_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_show_label (req_show_label),
      .req_start_new  (req_start_new),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   // decouple front and sequencer
   c39_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // emit bars
   c39_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bar_offset  (rsp_bar_offset),
      .rsp_wide_bar    (rsp_wide_bar),
      .rsp_label_valid (rsp_label_valid),
      .rsp_label_char  (rsp_label_char),
      .rsp_last_bar    (rsp_last_bar)
   );

endmodule

`default_nettype wire

// ===== verif/tb_code39_bar_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_code39_bar_encoder_unit
// Self-checking bench for the Code 39 bar encoder. Characters go in on the
// req_ channel and bars come back on the rsp_ channel. Outside the full-rate
// test both sides use random idle bursts. An in-bench bar predictor tracks
// the carried offset and queues five expected bars per encodable character.
// Each rsp_ beat is checked field by field against the oldest queued bar.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_code39_bar_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int MAX_REPORTS   = 10;

   // one expected bar, same fields as the rsp_ channel
   typedef struct packed {
      c39_pkg::offset_type offset;
      logic                wide;
      logic                label_valid;
      c39_pkg::char_type   label_char;
      logic                last;
   } bar_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   c39_pkg::char_type   req_char_code;
   logic                req_show_label;
   logic                req_start_new;
   logic                rsp_valid;
   logic                rsp_ready;
   c39_pkg::offset_type rsp_bar_offset;
   logic                rsp_wide_bar;
   logic                rsp_label_valid;
   c39_pkg::char_type   rsp_label_char;
   logic                rsp_last_bar;

   bar_type             expected_bars[$];
   c39_pkg::offset_type carry_units;
   int unsigned         symbols_sent;
   int unsigned         mismatch_count;
   int unsigned         cycle_count;
   logic                idle_enable;

   code39_bar_encoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_show_label  (req_show_label),
      .req_start_new   (req_start_new),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bar_offset  (rsp_bar_offset),
      .rsp_wide_bar    (rsp_wide_bar),
      .rsp_label_valid (rsp_label_valid),
      .rsp_label_char  (rsp_label_char),
      .rsp_last_bar    (rsp_last_bar)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // wide/narrow elements of an upper-case symbol, first element in bit 8
   function automatic logic [8:0] symbol_elements(input c39_pkg::char_type code);
      logic [8:0] elems;
      case (code)
         " ":     elems = 9'o304;
         "$":     elems = 9'o250;
         "%":     elems = 9'o052;
         "*":     elems = 9'o224;
         "+":     elems = 9'o212;
         "-":     elems = 9'o205;
         ".":     elems = 9'o604;
         "/":     elems = 9'o242;
         "0":     elems = 9'o064;
         "1":     elems = 9'o441;
         "2":     elems = 9'o141;
         "3":     elems = 9'o540;
         "4":     elems = 9'o061;
         "5":     elems = 9'o460;
         "6":     elems = 9'o160;
         "7":     elems = 9'o045;
         "8":     elems = 9'o444;
         "9":     elems = 9'o144;
         "A":     elems = 9'o411;
         "B":     elems = 9'o111;
         "C":     elems = 9'o510;
         "D":     elems = 9'o031;
         "E":     elems = 9'o430;
         "F":     elems = 9'o130;
         "G":     elems = 9'o015;
         "H":     elems = 9'o414;
         "I":     elems = 9'o114;
         "J":     elems = 9'o034;
         "K":     elems = 9'o403;
         "L":     elems = 9'o103;
         "M":     elems = 9'o502;
         "N":     elems = 9'o023;
         "O":     elems = 9'o422;
         "P":     elems = 9'o122;
         "Q":     elems = 9'o007;
         "R":     elems = 9'o406;
         "S":     elems = 9'o106;
         "T":     elems = 9'o026;
         "U":     elems = 9'o601;
         "V":     elems = 9'o301;
         "W":     elems = 9'o700;
         "X":     elems = 9'o221;
         "Y":     elems = 9'o620;
         "Z":     elems = 9'o320;
         default: elems = '0;
      endcase
      return elems;
   endfunction

   // bar predictor: queues the five bars of an encodable character, updates the carry
   task automatic predict_bars(input c39_pkg::char_type code, input logic label,
                               input logic clear);
      c39_pkg::char_type folded;
      logic [8:0]        elems;
      int unsigned       run;
      int                n;
      bar_type           bar;
      if (clear) begin
         carry_units = '0;
      end
      folded = (code >= "a" && code <= "z") ? c39_pkg::char_type'(code - 8'h20) : code;
      elems = symbol_elements(folded);
      if (elems != '0) begin
         symbols_sent++;
         run = carry_units;
         n = 0;
         for (int k = 8; k >= 0; k--) begin
            if (k % 2 == 0) begin
               // bar element: a wide bar sits one unit further on
               if (elems[k]) begin
                  run++;
               end
               bar.offset      = c39_pkg::offset_type'(run);
               bar.wide        = elems[k];
               bar.label_valid = (n == 0) && label;
               bar.label_char  = ((n == 0) && label) ? folded : '0;
               bar.last        = (n == 4);
               expected_bars.push_back(bar);
               n++;
               run = elems[k] ? 2 : 1;
            end else begin
               run += elems[k] ? 3 : 1;
            end
         end
         // intercharacter gap
         carry_units = c39_pkg::offset_type'(run + 1);
      end
   endtask

   // one req_ beat, with an optional idle burst ahead of it
   task automatic send_char(input c39_pkg::char_type code, input logic label,
                            input logic clear);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= code;
      req_show_label <= label;
      req_start_new  <= clear;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_bars(code, label, clear);
   endtask

   // hold the sender until every queued bar has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_bars.size() != 0) @(posedge clock);
   endtask

   // random encodable character, letters sometimes in lower case
   function automatic c39_pkg::char_type random_symbol();
      c39_pkg::char_type code;
      do code = c39_pkg::char_type'($urandom_range(8'h20, 8'h5a));
      while (symbol_elements(code) == '0);
      if (code >= "A" && code <= "Z" && $urandom_range(0, 2) == 0) begin
         code = c39_pkg::char_type'(code + 8'h20);
      end
      return code;
   endfunction

   // one framed code: start symbol, random body, stop symbol
   task automatic send_word(input int unsigned body_len);
      send_char("*", 1'($urandom_range(0, 1)), 1'($urandom_range(0, 7) != 0));
      repeat (body_len) begin
         send_char(random_symbol(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 9) == 0));
      end
      send_char("*", 1'($urandom_range(0, 1)), 1'b0);
   endtask

   // field extremes, every symbol class, invalid codes with label and clear
   task automatic test_directed_edges();
      send_char("*", 1'b1, 1'b1);
      send_char("A", 1'b1, 1'b0);
      send_char("z", 1'b1, 1'b0);
      send_char("0", 1'b0, 1'b0);
      send_char("9", 1'b1, 1'b0);
      send_char(" ", 1'b0, 1'b0);
      send_char("$", 1'b1, 1'b0);
      send_char("%", 1'b0, 1'b0);
      send_char("+", 1'b0, 1'b0);
      send_char("-", 1'b1, 1'b0);
      send_char(".", 1'b0, 1'b0);
      send_char("/", 1'b0, 1'b0);
      send_char("Q", 1'b0, 1'b0);
      send_char("W", 1'b1, 1'b0);
      send_char(8'h00, 1'b1, 1'b0);
      send_char(8'hff, 1'b1, 1'b0);
      send_char("@", 1'b0, 1'b0);
      send_char(8'h5b, 1'b0, 1'b0);
      send_char(8'h60, 1'b1, 1'b0);
      send_char(8'h7b, 1'b0, 1'b0);
      send_char(8'h80, 1'b1, 1'b1);
      send_char("*", 1'b0, 1'b0);
      send_char("a", 1'b1, 1'b1);
      send_char("*", 1'b1, 1'b0);
   endtask

   // mostly framed codes with random content, some raw noise beats
   task automatic test_random_codes(input int unsigned target);
      target += symbols_sent;
      while (symbols_sent < target) begin
         if ($urandom_range(0, 6) == 0) begin
            send_char(c39_pkg::char_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            send_word($urandom_range(0, 8));
            if ($urandom_range(0, 5) == 0) begin
               wait_drained();
            end
         end
      end
   endtask

   // sender holds off until the encoder is empty, then restarts a code
   task automatic test_drain_pause();
      send_word(2);
      wait_drained();
      send_word(3);
   endtask

   // no idling on either side: full rate back to back
   task automatic test_full_rate();
      idle_enable = 1'b0;
      send_word(6);
      send_word(10);
      send_char(8'h7f, 1'b1, 1'b1);
      send_word(4);
   endtask

   // receiver ready: stall bursts mixed with clean stretches
   initial begin
      int unsigned stall_left;
      int unsigned run_left;
      stall_left = 0;
      run_left   = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!idle_enable) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_ready <= 1'b1;
            run_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
         end else begin
            rsp_ready <= 1'b1;
            run_left = $urandom_range(1, 20);
         end
      end
   end

   // bar checker: each rsp_ beat against the oldest expected bar
   initial mismatch_count = 0;
   always @(posedge clock) begin
      bar_type got;
      bar_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = '{rsp_bar_offset, rsp_wide_bar, rsp_label_valid, rsp_label_char, rsp_last_bar};
         if (expected_bars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("t=%0t unexpected bar: off=%0d wide=%b lv=%b lc=%h last=%b",
                        $realtime, got.offset, got.wide, got.label_valid, got.label_char,
                        got.last);
            end
         end else begin
            want = expected_bars.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("t=%0t bar mismatch: exp off=%0d wide=%b lv=%b lc=%h last=%b",
                           $realtime, want.offset, want.wide, want.label_valid,
                           want.label_char, want.last);
                  $display("                  got off=%0d wide=%b lv=%b lc=%h last=%b",
                           got.offset, got.wide, got.label_valid, got.label_char,
                           got.last);
               end
            end
         end
      end
   end

   // test sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_char_code  = '0;
      req_show_label = 1'b0;
      req_start_new  = 1'b0;
      idle_enable    = 1'b1;
      carry_units    = '0;
      symbols_sent   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_random_codes(100);
      test_drain_pause();
      test_full_rate();

      // drain, then allow the pipeline latency to expose stray bars
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/c39_pkg.sv
rtl/core/c39_front.sv
rtl/core/c39_queue.sv
rtl/core/c39_back.sv
rtl/core/code39_bar_encoder_unit.sv
verif/tb_code39_bar_encoder_unit.sv
